>>> design/assert_macros.svh
// assertion macros for the handshake unit
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PBSH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("pbsh check failed");
`define PBSH_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("pbsh check failed");
`else
`define PBSH_ASSERT(lbl, clk, rstn, prop)
`define PBSH_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> design/pbsh_pkg.sv
// shared types and constants for the handshake unit
// no dependencies
package pbsh_pkg;

    localparam int SEND_DEPTH = 32;
    localparam int RECV_DEPTH = 32;
    localparam int SEND_AW = $clog2(SEND_DEPTH + 2);
    localparam int RECV_AW = $clog2(RECV_DEPTH + 1);
    localparam logic [7:0] EOL_RESET = 8'd13;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_RESET = 2'd1,
        MODE_READ  = 2'd2,
        MODE_WRITE = 2'd3
    } mode_t;

    typedef struct packed {
        logic       is_load;
        logic       sel;
        logic       hrst;
        logic       rnw;
        logic [7:0] bus;
        logic [7:0] ch;
        logic       first;
    } item_t;

endpackage

>>> design/parallel_bus_slave_handshake_unit.sv
// top level of the bus slave handshake unit
// depends on pbsh_pkg, pbsh_front and pbsh_back
//
// A poll item passes through the sequence engine's fetch, execute and status result
// states, plus a check state before the status result when a host read advances
// the send position, since the next send byte comes through the store's one
// registered read port. A load item stays in the fetch state. A finished command
// adds a state that starts the receive store read, then one result per command
// byte; an empty command adds one result. A two-item queue sits in front of the
// engine, a result register behind it, so input and output stall independently.
module parallel_bus_slave_handshake_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic       select_n,
    input  logic       host_reset_n,
    input  logic       read_not_write,
    input  logic [7:0] bus_in,
    input  logic [7:0] send_char,
    input  logic       send_first,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic       int_n_level,
    output logic       bus_drive,
    output logic [7:0] bus_out,
    output logic       busy_res,
    output logic [7:0] cmd_char,
    output logic       cmd_last
);

    logic [7:0] eol_reg;
    logic q_valid, q_take;
    pbsh_pkg::item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eol_reg <= pbsh_pkg::EOL_RESET;
        else if (cfg_we)
            eol_reg <= cfg_wdata;
    end

    pbsh_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .select_n(select_n), .host_reset_n(host_reset_n),
        .read_not_write(read_not_write), .bus_in(bus_in), .send_char(send_char),
        .send_first(send_first), .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
    );

    pbsh_back u_back
    (
        .clk(clk), .rst_n(rst_n), .eol(eol_reg), .q_valid(q_valid), .q_item(q_item),
        .q_take(q_take), .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .int_n_level(int_n_level), .bus_drive(bus_drive), .bus_out(bus_out),
        .busy_res(busy_res), .cmd_char(cmd_char), .cmd_last(cmd_last)
    );

endmodule

>>> design/pbsh_front.sv
// front part: classifies input items and queues them for the back part
// depends on pbsh_pkg
module pbsh_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           operation,
    input  logic           select_n,
    input  logic           host_reset_n,
    input  logic           read_not_write,
    input  logic [7:0]     bus_in,
    input  logic [7:0]     send_char,
    input  logic           send_first,
    output logic           q_valid,
    output pbsh_pkg::item_t q_item,
    input  logic           q_take
);

    pbsh_pkg::item_t slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push, pop;
    pbsh_pkg::item_t item;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_take && q_valid;
    assign q_item   = slot_reg[rp_reg];

    always_comb
    begin
        item.is_load = operation;
        item.sel     = !select_n;
        item.hrst    = !host_reset_n;
        item.rnw     = read_not_write;
        item.bus     = bus_in;
        item.ch      = send_char;
        item.first   = send_first;
        cnt_next     = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

endmodule

>>> design/pbsh_back.sv
// back part: runs the bus sequences, holds the send and receive stores, emits results
// depends on pbsh_pkg and assert_macros.svh
`include "assert_macros.svh"
module pbsh_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      eol,
    input  logic            q_valid,
    input  pbsh_pkg::item_t q_item,
    output logic            q_take,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            kind,
    output logic            int_n_level,
    output logic            bus_drive,
    output logic [7:0]      bus_out,
    output logic            busy_res,
    output logic [7:0]      cmd_char,
    output logic            cmd_last
);

    localparam int SAW = pbsh_pkg::SEND_AW;
    localparam int RAW = pbsh_pkg::RECV_AW;
    localparam logic [SAW-1:0] SEND_END = SAW'(pbsh_pkg::SEND_DEPTH);
    localparam logic [RAW-1:0] RECV_END = RAW'(pbsh_pkg::RECV_DEPTH);
    localparam logic [RAW-1:0] RECV_LASTIX = RAW'(pbsh_pkg::RECV_DEPTH - 1);

    typedef enum logic [6:0] {
        ST_FETCH = 7'b0000001,
        ST_EXEC  = 7'b0000010,
        ST_CHK   = 7'b0000100,
        ST_STAT  = 7'b0001000,
        ST_CFIRST = 7'b0010000,
        ST_CMD   = 7'b0100000,
        ST_TAIL  = 7'b1000000
    } state_t;

    state_t st_reg, st_next;
    pbsh_pkg::item_t it_reg, it_next;
    pbsh_pkg::mode_t mode_reg, mode_next;
    logic rstph_reg, rstph_next, rdph_reg, rdph_next;
    logic [1:0] wrph_reg, wrph_next;
    logic [SAW-1:0] req_reg, req_next, xmit_reg, xmit_next, load_reg, load_next;
    logic [RAW-1:0] rpos_reg, rpos_next, cidx_reg, cidx_next;
    logic closed_reg, closed_next, intl_reg, intl_next, drv_reg, drv_next;
    logic [7:0] ob_reg, ob_next, ccur_reg, ccur_next;
    logic cpend_reg, cpend_next;
    logic ov_reg, ov_next, ok_reg, ok_next, oi_reg, oi_next, od_reg, od_next;
    logic ob2_busy_reg, ob2_busy_next, ol_reg, ol_next;
    logic [7:0] oo_reg, oo_next, oc_reg, oc_next;
    logic out_free;

    // stores
    logic [7:0] smem [pbsh_pkg::SEND_DEPTH + 1];
    logic [7:0] rmem [pbsh_pkg::RECV_DEPTH + 1];
    logic [pbsh_pkg::SEND_DEPTH:0] svld_reg;
    logic [pbsh_pkg::RECV_DEPTH:0] rvld_reg;
    logic [7:0] srd_reg, rrd_reg;
    logic srv_reg, rrv_reg;
    logic [7:0] s_data, r_data;
    logic s_we, s_re, s_flush, r_we, r_re, r_flush;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [RAW-1:0] r_waddr, r_raddr;
    logic [7:0] s_wdata, r_wdata;

    assign s_data   = srv_reg ? srd_reg : 8'd0;
    assign r_data   = rrv_reg ? rrd_reg : 8'd0;
    assign out_free = !ov_reg || !out_stall;

    assign out_valid   = ov_reg;
    assign kind        = ok_reg;
    assign int_n_level = oi_reg;
    assign bus_drive   = od_reg;
    assign bus_out     = oo_reg;
    assign busy_res    = ob2_busy_reg;
    assign cmd_char    = oc_reg;
    assign cmd_last    = ol_reg;

    always_comb
    begin
        st_next = st_reg; it_next = it_reg; mode_next = mode_reg;
        rstph_next = rstph_reg; rdph_next = rdph_reg; wrph_next = wrph_reg;
        req_next = req_reg; xmit_next = xmit_reg; load_next = load_reg;
        rpos_next = rpos_reg; cidx_next = cidx_reg; closed_next = closed_reg;
        intl_next = intl_reg; drv_next = drv_reg; ob_next = ob_reg;
        ccur_next = ccur_reg; cpend_next = cpend_reg;
        ov_next = ov_reg && out_stall; ok_next = ok_reg; oi_next = oi_reg;
        od_next = od_reg; oo_next = oo_reg; ob2_busy_next = ob2_busy_reg;
        oc_next = oc_reg; ol_next = ol_reg;
        q_take = 1'b0;
        s_we = 1'b0; s_re = 1'b0; s_flush = 1'b0; s_waddr = load_reg;
        s_raddr = xmit_reg; s_wdata = 8'd0;
        r_we = 1'b0; r_re = 1'b0; r_flush = 1'b0; r_waddr = rpos_reg;
        r_raddr = rpos_reg; r_wdata = 8'd0;

        unique case (st_reg)
            ST_FETCH:
            begin
                q_take = 1'b1;
                if (q_valid)
                begin
                    it_next = q_item;
                    if (q_item.is_load)
                    begin
                        if (q_item.first || !closed_reg)
                        begin
                            s_we    = 1'b1;
                            s_waddr = q_item.first ? '0 : load_reg;
                            if (q_item.ch == 8'd0 || s_waddr >= SEND_END)
                            begin
                                s_wdata     = eol;
                                closed_next = 1'b1;
                                load_next   = s_waddr;
                            end
                            else
                            begin
                                s_wdata     = q_item.ch;
                                closed_next = 1'b0;
                                load_next   = s_waddr + SAW'(1);
                            end
                        end
                    end
                    else
                    begin
                        s_re    = 1'b1;
                        r_re    = 1'b1;
                        st_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                st_next = ST_STAT;
                unique case (mode_reg)
                    pbsh_pkg::MODE_IDLE:
                    begin
                        if (it_reg.sel)
                        begin
                            if (it_reg.hrst)
                                mode_next = pbsh_pkg::MODE_RESET;
                            else if (it_reg.rnw)
                                mode_next = pbsh_pkg::MODE_READ;
                            else
                                mode_next = pbsh_pkg::MODE_WRITE;
                        end
                        else if (req_reg == xmit_reg && s_data != 8'd0)
                        begin
                            req_next  = req_reg + SAW'(1);
                            intl_next = 1'b0;
                        end
                    end
                    pbsh_pkg::MODE_RESET:
                    begin
                        if (!rstph_reg)
                        begin
                            s_flush = 1'b1; r_flush = 1'b1;
                            req_next = '0; xmit_next = '0; load_next = '0;
                            closed_next = 1'b0; rpos_next = '0;
                            drv_next = 1'b0; intl_next = 1'b0; rstph_next = 1'b1;
                        end
                        else if (!it_reg.sel)
                        begin
                            intl_next = 1'b1; rstph_next = 1'b0;
                            mode_next = pbsh_pkg::MODE_IDLE;
                        end
                    end
                    pbsh_pkg::MODE_READ:
                    begin
                        if (it_reg.sel && it_reg.hrst)
                        begin
                            mode_next = pbsh_pkg::MODE_IDLE;
                        end
                        else if (!rdph_reg)
                        begin
                            drv_next = 1'b1; ob_next = s_data;
                            intl_next = 1'b1; rdph_next = 1'b1;
                        end
                        else if (!it_reg.rnw)
                        begin
                            drv_next = 1'b0; mode_next = pbsh_pkg::MODE_IDLE;
                            rdph_next = 1'b0;
                            if (xmit_reg < SEND_END)
                            begin
                                xmit_next = xmit_reg + SAW'(1);
                                s_re      = 1'b1;
                                s_raddr   = xmit_reg + SAW'(1);
                                st_next   = ST_CHK;
                            end
                            else
                            begin
                                s_flush = 1'b1;
                                req_next = '0; xmit_next = '0; load_next = '0;
                                closed_next = 1'b0;
                            end
                        end
                    end
                    pbsh_pkg::MODE_WRITE:
                    begin
                        if (it_reg.sel && it_reg.hrst)
                        begin
                            mode_next = pbsh_pkg::MODE_IDLE;
                        end
                        else if (wrph_reg == 2'd0)
                        begin
                            r_we = 1'b1; r_wdata = it_reg.bus;
                            intl_next = 1'b0; wrph_next = 2'd1;
                        end
                        else if (wrph_reg == 2'd1)
                        begin
                            if (!it_reg.sel)
                            begin
                                intl_next = 1'b1; wrph_next = 2'd2;
                            end
                        end
                        else if (it_reg.rnw)
                        begin
                            if (r_data == eol)
                            begin
                                r_we = 1'b1; r_wdata = 8'd0; cpend_next = 1'b1;
                            end
                            else if (rpos_reg < RECV_END)
                            begin
                                rpos_next = rpos_reg + RAW'(1);
                            end
                            wrph_next = 2'd0; mode_next = pbsh_pkg::MODE_IDLE;
                        end
                    end
                    default:
                    begin
                        mode_next = pbsh_pkg::MODE_IDLE;
                    end
                endcase
            end
            ST_CHK:
            begin
                if (s_data == 8'd0)
                begin
                    s_flush = 1'b1;
                    req_next = '0; xmit_next = '0; load_next = '0; closed_next = 1'b0;
                end
                st_next = ST_STAT;
            end
            ST_STAT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1; ok_next = 1'b0; oi_next = intl_reg;
                    od_next = drv_reg; oo_next = ob_reg;
                    ob2_busy_next = (mode_reg != pbsh_pkg::MODE_IDLE);
                    oc_next = 8'd0; ol_next = 1'b0;
                    if (cpend_reg)
                    begin
                        r_re = 1'b1; r_raddr = '0; cidx_next = '0;
                        st_next = ST_CFIRST;
                    end
                    else
                    begin
                        st_next = ST_FETCH;
                    end
                end
            end
            ST_CFIRST:
            begin
                if (r_data == 8'd0)
                begin
                    if (out_free)
                    begin
                        ov_next = 1'b1; ok_next = 1'b1; oi_next = 1'b0; od_next = 1'b0;
                        oo_next = 8'd0; ob2_busy_next = 1'b0; oc_next = 8'd0;
                        ol_next = 1'b1;
                        r_flush = 1'b1; rpos_next = '0; cpend_next = 1'b0;
                        st_next = ST_FETCH;
                    end
                end
                else
                begin
                    ccur_next = r_data;
                    r_re = 1'b1; r_raddr = RAW'(1);
                    st_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1; ok_next = 1'b1; oi_next = 1'b0; od_next = 1'b0;
                    oo_next = 8'd0; ob2_busy_next = 1'b0; oc_next = ccur_reg;
                    ol_next = (r_data == 8'd0);
                    if (r_data == 8'd0)
                    begin
                        r_flush = 1'b1; rpos_next = '0; cpend_next = 1'b0;
                        st_next = ST_FETCH;
                    end
                    else
                    begin
                        ccur_next = r_data;
                        cidx_next = cidx_reg + RAW'(1);
                        if (cidx_reg + RAW'(1) == RECV_LASTIX)
                        begin
                            st_next = ST_TAIL;
                        end
                        else
                        begin
                            r_re = 1'b1; r_raddr = cidx_reg + RAW'(2);
                        end
                    end
                end
            end
            ST_TAIL:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1; ok_next = 1'b1; oi_next = 1'b0; od_next = 1'b0;
                    oo_next = 8'd0; ob2_busy_next = 1'b0; oc_next = ccur_reg;
                    ol_next = 1'b1;
                    r_flush = 1'b1; rpos_next = '0; cpend_next = 1'b0;
                    st_next = ST_FETCH;
                end
            end
            default:
            begin
                st_next = ST_FETCH;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            smem[s_waddr] <= s_wdata;
        if (s_re)
            srd_reg <= smem[s_raddr];
        if (r_we)
            rmem[r_waddr] <= r_wdata;
        if (r_re)
            rrd_reg <= rmem[r_raddr];
        it_reg <= it_next;
    end

    always_ff @(posedge clk)
    begin
        ccur_reg <= ccur_next;
        ok_reg <= ok_next; oi_reg <= oi_next; od_reg <= od_next; oo_reg <= oo_next;
        ob2_busy_reg <= ob2_busy_next; oc_reg <= oc_next; ol_reg <= ol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_FETCH; mode_reg <= pbsh_pkg::MODE_IDLE;
            rstph_reg <= 1'b0; rdph_reg <= 1'b0; wrph_reg <= 2'd0;
            req_reg <= '0; xmit_reg <= '0; load_reg <= '0; rpos_reg <= '0;
            cidx_reg <= '0; closed_reg <= 1'b0; intl_reg <= 1'b1; drv_reg <= 1'b0;
            ob_reg <= 8'd0; cpend_reg <= 1'b0; ov_reg <= 1'b0;
            svld_reg <= '0; rvld_reg <= '0; srv_reg <= 1'b0; rrv_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; mode_reg <= mode_next;
            rstph_reg <= rstph_next; rdph_reg <= rdph_next; wrph_reg <= wrph_next;
            req_reg <= req_next; xmit_reg <= xmit_next; load_reg <= load_next;
            rpos_reg <= rpos_next; cidx_reg <= cidx_next; closed_reg <= closed_next;
            intl_reg <= intl_next; drv_reg <= drv_next; ob_reg <= ob_next;
            cpend_reg <= cpend_next; ov_reg <= ov_next;
            if (s_re)
                srv_reg <= svld_reg[s_raddr];
            if (r_re)
                rrv_reg <= rvld_reg[r_raddr];
            if (s_flush)
                svld_reg <= '0;
            else if (s_we)
                svld_reg[s_waddr] <= 1'b1;
            if (r_flush)
                rvld_reg <= '0;
            else if (r_we)
                rvld_reg[r_waddr] <= 1'b1;
        end
    end

    `PBSH_NEVER(a_take_only_fetch, clk, rst_n, q_take && st_reg != ST_FETCH)
    `PBSH_NEVER(a_load_in_range, clk, rst_n, load_reg > SEND_END)
    `PBSH_NEVER(a_xmit_in_range, clk, rst_n, xmit_reg > SEND_END)
    `PBSH_NEVER(a_rpos_in_range, clk, rst_n, rpos_reg > RECV_END)

endmodule
